/* hw/rtl/record_bubble_sorter_defines.svh */
// Assertion macros shared by the record bubble sorter RTL.
`ifndef RECORD_BUBBLE_SORTER_DEFINES_SVH
`define RECORD_BUBBLE_SORTER_DEFINES_SVH
`ifndef SYNTHESIS
`define RBS_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("record_bubble_sorter assertion failed");
`define RBS_ASSERT(label, prop) `RBS_ASSERT_CLK(label, clock, reset, prop)
`else
`define RBS_ASSERT_CLK(label, clk, rst, prop)
`define RBS_ASSERT(label, prop)
`endif
`endif

/* hw/rtl/rbs_pkg.sv */
// Types, constants and helpers of the record bubble sorter.
`default_nettype none
package rbs_pkg;
   localparam int unsigned MAX_RECORDS_DEF = 32;
   localparam int unsigned GRADE_W = 8;
   localparam int unsigned LEN_W = 6;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned CHUNK_W = 56;
   localparam int unsigned NAME_CHUNKS = 7;
   localparam int unsigned NAME_BYTES = 49;
   localparam int unsigned NAME_BITS = NAME_CHUNKS * CHUNK_W;

   localparam logic [MODE_W-1:0] MODE_GRADE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALPHA = 2'd2;

   typedef struct packed {
      logic [GRADE_W-1:0] grade;
      logic [LEN_W-1:0] length;
      logic [NAME_BITS-1:0] name;
   } record_type;

   // Chunk zero sits in the top bits of the name so that byte order follows bit order.
   function automatic logic [CHUNK_W-1:0] chunk_get(input logic [NAME_BITS-1:0] name,
                                                    input int unsigned k);
      return name[(NAME_CHUNKS - 1 - k) * CHUNK_W +: CHUNK_W];
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/rbs_if.sv */
// Handshake channel interfaces of the record bubble sorter.
`default_nettype none
interface rbs_req_if;
   logic valid;
   logic ready;
   logic [rbs_pkg::GRADE_W-1:0] grade;
   logic [rbs_pkg::LEN_W-1:0] name_length;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_0;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_1;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_2;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_3;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_4;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_5;
   logic [rbs_pkg::CHUNK_W-1:0] name_chunk_6;
   logic last_record;
   modport source (output valid, grade, name_length, name_chunk_0, name_chunk_1,
                   name_chunk_2, name_chunk_3, name_chunk_4, name_chunk_5,
                   name_chunk_6, last_record, input ready);
   modport sink (input valid, grade, name_length, name_chunk_0, name_chunk_1,
                 name_chunk_2, name_chunk_3, name_chunk_4, name_chunk_5,
                 name_chunk_6, last_record, output ready);
endinterface

interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic [rbs_pkg::GRADE_W-1:0] out_grade;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_0;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_1;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_2;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_3;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_4;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_5;
   logic [rbs_pkg::CHUNK_W-1:0] out_chunk_6;
   logic out_last;
   logic records_dropped;
   modport source (output valid, out_grade, out_chunk_0, out_chunk_1, out_chunk_2,
                   out_chunk_3, out_chunk_4, out_chunk_5, out_chunk_6, out_last,
                   records_dropped, input ready);
   modport sink (input valid, out_grade, out_chunk_0, out_chunk_1, out_chunk_2,
                 out_chunk_3, out_chunk_4, out_chunk_5, out_chunk_6, out_last,
                 records_dropped, output ready);
endinterface

interface rbs_csr_if;
   logic valid;
   logic ready;
   logic [rbs_pkg::MODE_W-1:0] sort_mode;
   modport source (output valid, sort_mode, input ready);
   modport sink (input valid, sort_mode, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rbs_compare.sv */
// Record comparator: decides whether record a must move behind record b.
`default_nettype none
module rbs_compare (
   input wire logic [rbs_pkg::MODE_W-1:0] sort_mode,
   input wire rbs_pkg::record_type rec_a,
   input wire rbs_pkg::record_type rec_b,
   output logic moves_behind
);
   localparam int unsigned NB = rbs_pkg::NAME_BYTES;
   localparam int unsigned NBITS = rbs_pkg::NAME_BITS;

   logic [NB-1:0] zero_byte;
   logic [NB-1:0] keep_byte;
   logic [NBITS-1:0] masked_a;
   logic [NBITS-1:0] masked_b;

   // A name ends at record a's first zero byte; bytes of both names after it take no part in the order.
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         zero_byte[i] = (rec_a.name[NBITS - 1 - 8 * i -: 8] == 8'd0);
      end
      for (int i = 0; i < NB; i++) begin
         keep_byte[i] = ~|(zero_byte & ((NB'(1) << i) - NB'(1)));
      end
      for (int i = 0; i < NB; i++) begin
         masked_a[NBITS - 1 - 8 * i -: 8] = keep_byte[i] ? rec_a.name[NBITS - 1 - 8 * i -: 8]
                                                          : 8'd0;
         masked_b[NBITS - 1 - 8 * i -: 8] = keep_byte[i] ? rec_b.name[NBITS - 1 - 8 * i -: 8]
                                                          : 8'd0;
      end
   end

   always_comb begin
      unique case (sort_mode)
         rbs_pkg::MODE_GRADE: moves_behind = (rec_a.grade < rec_b.grade);
         rbs_pkg::MODE_LENGTH: moves_behind = (rec_a.length > rec_b.length);
         rbs_pkg::MODE_ALPHA: moves_behind = (masked_a > masked_b);
         default: moves_behind = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

/* hw/rtl/record_bubble_sorter.sv */
// Record bubble sorter: loads a group of records into a record memory, bubble sorts it there
// and streams the sorted group out. Loading takes one record transfer per cycle. After the
// record marked last, bubble passes run over the group; the single read port of the record
// memory and its registered read give every neighbor step a read, a compare and a write-back
// state. Passes repeat until one makes no swap, so at most n passes run over n records.
// Emission then reads each record into the result register and holds it there until the
// result side takes it. Records beyond MAX_RECORDS are dropped and every result of that
// group carries records_dropped. No input transfer is taken while a group is sorted or sent.
`default_nettype none
`include "record_bubble_sorter_defines.svh"
module record_bubble_sorter #(
   parameter int unsigned MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   rbs_req_if.sink req_bus,
   rbs_rsp_if.source rsp_bus,
   rbs_csr_if.sink csr_bus
);
   localparam int unsigned ADDR_W = $clog2(MAX_RECORDS);
   localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int unsigned LEN_W = rbs_pkg::LEN_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_P_RD0 = 4'd1;
   localparam logic [3:0] S_P_LD0 = 4'd2;
   localparam logic [3:0] S_P_RD = 4'd3;
   localparam logic [3:0] S_P_CMP = 4'd4;
   localparam logic [3:0] S_P_WR = 4'd5;
   localparam logic [3:0] S_P_END = 4'd6;
   localparam logic [3:0] S_E_RD = 4'd7;
   localparam logic [3:0] S_E_LD = 4'd8;
   localparam logic [3:0] S_E_WAIT = 4'd9;

   rbs_pkg::record_type rec_mem [MAX_RECORDS];
   rbs_pkg::record_type rd_data_ff;

   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic overflow_ff, overflow_in;
   logic swap_ff, swap_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rbs_pkg::MODE_W-1:0] sort_mode_ff, sort_mode_in;
   rbs_pkg::record_type held_ff, held_in;
   logic gt_ff, gt_in;
   rbs_pkg::record_type out_rec_ff, out_rec_in;
   logic out_last_ff, out_last_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   rbs_pkg::record_type wr_data;
   rbs_pkg::record_type req_rec;
   logic [CNT_W-1:0] idx_plus;
   logic req_xfer;
   logic rsp_xfer;
   logic cmp_result;

   rbs_compare u_compare (
      .sort_mode(sort_mode_ff),
      .rec_a(held_ff),
      .rec_b(rd_data_ff),
      .moves_behind(cmp_result)
   );

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_bus.ready;
   assign idx_plus = idx_ff + CNT_W'(1);

   always_comb begin
      req_rec.grade = req_bus.grade;
      req_rec.length = (req_bus.name_length > LEN_W'(rbs_pkg::NAME_BYTES))
                       ? LEN_W'(rbs_pkg::NAME_BYTES) : req_bus.name_length;
      req_rec.name = {req_bus.name_chunk_0, req_bus.name_chunk_1, req_bus.name_chunk_2,
                      req_bus.name_chunk_3, req_bus.name_chunk_4, req_bus.name_chunk_5,
                      req_bus.name_chunk_6};
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      overflow_in = overflow_ff;
      swap_in = swap_ff;
      rsp_valid_in = rsp_valid_ff;
      held_in = held_ff;
      gt_in = cmp_result;
      out_rec_in = out_rec_ff;
      out_last_in = out_last_ff;
      sort_mode_in = (csr_bus.valid) ? csr_bus.sort_mode : sort_mode_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = req_rec;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (count_ff < CNT_W'(MAX_RECORDS)) begin
                  wr_en = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_bus.last_record) begin
                  idx_in = '0;
                  state_in = S_P_RD0;
               end
            end
         end
         S_P_RD0: state_in = S_P_LD0;
         S_P_LD0: begin
            held_in = rd_data_ff;
            swap_in = 1'b0;
            if (count_ff == CNT_W'(1)) begin
               state_in = S_P_END;
            end else begin
               idx_in = CNT_W'(1);
               state_in = S_P_RD;
            end
         end
         S_P_RD: state_in = S_P_CMP;
         S_P_CMP: state_in = S_P_WR;
         S_P_WR: begin
            wr_en = 1'b1;
            wr_addr = ADDR_W'(idx_ff - CNT_W'(1));
            if (gt_ff) begin
               wr_data = rd_data_ff;
               swap_in = 1'b1;
            end else begin
               wr_data = held_ff;
               held_in = rd_data_ff;
            end
            idx_in = idx_plus;
            state_in = (idx_plus == count_ff) ? S_P_END : S_P_RD;
         end
         S_P_END: begin
            wr_en = 1'b1;
            wr_addr = ADDR_W'(count_ff - CNT_W'(1));
            wr_data = held_ff;
            idx_in = '0;
            state_in = swap_ff ? S_P_RD0 : S_E_RD;
         end
         S_E_RD: state_in = S_E_LD;
         S_E_LD: begin
            out_rec_in = rd_data_ff;
            out_last_in = (idx_plus == count_ff);
            rsp_valid_in = 1'b1;
            state_in = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0;
                  overflow_in = 1'b0;
                  swap_in = 1'b0;
                  idx_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_plus;
                  state_in = S_E_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= rec_mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         count_ff <= '0;
         overflow_ff <= 1'b0;
         swap_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sort_mode_ff <= rbs_pkg::MODE_GRADE;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         count_ff <= count_in;
         overflow_ff <= overflow_in;
         swap_ff <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
         sort_mode_ff <= sort_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      gt_ff <= gt_in;
      out_rec_ff <= out_rec_in;
      out_last_ff <= out_last_in;
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_grade = out_rec_ff.grade;
   assign rsp_bus.out_chunk_0 = rbs_pkg::chunk_get(out_rec_ff.name, 0);
   assign rsp_bus.out_chunk_1 = rbs_pkg::chunk_get(out_rec_ff.name, 1);
   assign rsp_bus.out_chunk_2 = rbs_pkg::chunk_get(out_rec_ff.name, 2);
   assign rsp_bus.out_chunk_3 = rbs_pkg::chunk_get(out_rec_ff.name, 3);
   assign rsp_bus.out_chunk_4 = rbs_pkg::chunk_get(out_rec_ff.name, 4);
   assign rsp_bus.out_chunk_5 = rbs_pkg::chunk_get(out_rec_ff.name, 5);
   assign rsp_bus.out_chunk_6 = rbs_pkg::chunk_get(out_rec_ff.name, 6);
   assign rsp_bus.out_last = out_last_ff;
   assign rsp_bus.records_dropped = overflow_ff;

   `RBS_ASSERT(a_no_load_while_sending, rsp_bus.valid |-> !req_bus.ready)
   `RBS_ASSERT(a_count_bounded, count_ff <= CNT_W'(MAX_RECORDS))
   `RBS_ASSERT(a_overflow_only_full, overflow_ff |-> (count_ff == CNT_W'(MAX_RECORDS)))
   `RBS_ASSERT(a_group_closes, (rsp_xfer && out_last_ff) |=> (state_ff == S_IDLE && count_ff == '0))
endmodule
`default_nettype wire
